[rtl/bounded_stack_engine_core_defines.svh]
// Assertion helpers shared by the stack engine RTL.
`ifndef BOUNDED_STACK_ENGINE_CORE_DEFINES_SVH
`define BOUNDED_STACK_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BSE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bse assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BSE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bse assertion failed");

`endif

[rtl/bse_pkg.sv]
`default_nettype none

package bse_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int WORD_W          = 32;
    localparam int CMD_W           = 3;
    localparam int STATUS_W        = 2;
    localparam int COUNT_W         = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_PEEK    = 3'd2,
        CMD_MAX     = 3'd3,
        CMD_REVERSE = 3'd4,
        CMD_CLEAR   = 3'd5
    } cmd_e_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MAX,
        S_REV_RD,
        S_REV_WA,
        S_REV_WB
    } state_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        status_t                  status;
        logic [COUNT_W-1:0]       count;
    } res_t;

endpackage

`default_nettype wire

[rtl/bse_stack_mem.sv]
`default_nettype none

// Entry store: one write port, two read ports, registered read data.
module bse_stack_mem
    import bse_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        we,
    input  wire logic [$clog2(DEPTH)-1:0]    waddr,
    input  wire logic signed [WORD_W-1:0]    wdata,
    input  wire logic [$clog2(DEPTH)-1:0]    raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0]    raddr_b,
    output logic signed [WORD_W-1:0]         rdata_a,
    output logic signed [WORD_W-1:0]         rdata_b
);

    logic signed [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

[rtl/bounded_stack_engine_core.sv]
// Bounded LIFO stack of signed 32-bit words.
// Input channel (s_valid/s_ready): one command request per item with
// s_command (push, pop, peek, max, reverse, clear) and s_push_value.
// Output channel (m_valid/m_ready): exactly one result per request with
// m_result_value, m_status and m_entry_count (count after the command).
// Push, clear, no-op codes and trivial reverse/empty cases answer straight
// from the request with no memory read; pop and peek take one read through
// the entry memory; max streams one memory read per entry through a
// compare; reverse swaps each pair by reading both ends, writing the low
// end, then writing the high end on the single write port.
// One request is in flight at a time; s_ready drops while a pop, peek, max
// or reverse is under way.
// Results land in an output register backed by one skid entry, so a new
// request is taken while a finished result waits; once both are full,
// s_ready stays low until the receiver drains.
// Reset (aresetn low, synchronous) empties the stack and drops all pending
// results. Memory contents are not cleared: only written entries are read.
`default_nettype none

`include "bounded_stack_engine_core_defines.svh"

module bounded_stack_engine_core
    import bse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [CMD_W-1:0]          s_command,
    input  wire logic signed [WORD_W-1:0]  s_push_value,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [WORD_W-1:0]       m_result_value,
    output logic [STATUS_W-1:0]            m_status,
    output logic [COUNT_W-1:0]             m_entry_count
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int FILL_W = $clog2(STACK_DEPTH + 1);

    state_t state_reg, state_next;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] idx_reg, idx_next;        // max walk read pointer
    logic              rd_pend_reg, rd_pend_next;
    logic              first_reg, first_next;
    logic signed [WORD_W-1:0] max_reg, max_next;
    logic [ADDR_W-1:0] lo_reg, lo_next;          // reverse low/high ends
    logic [ADDR_W-1:0] hi_reg, hi_next;
    logic signed [WORD_W-1:0] tmp_reg, tmp_next;

    res_t out_reg, skid_reg;
    logic m_valid_reg, skid_valid_reg;

    // memory control
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr, mem_raddr_a, mem_raddr_b;
    logic signed [WORD_W-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

    logic accept;
    logic res_fire;
    res_t res;
    logic rev_more;

    assign s_ready = (state_reg == S_IDLE) && !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    // another pair left once the ends would still be apart after stepping
    assign rev_more = (({1'b0, hi_reg} - {1'b0, lo_reg}) > (ADDR_W+1)'(2));

    bse_stack_mem #(
        .DEPTH (STACK_DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_command)
                        CMD_POP, CMD_PEEK: begin
                            if (fill_reg != '0) state_next = S_READ;
                        end
                        CMD_MAX: begin
                            if (fill_reg != '0) state_next = S_MAX;
                        end
                        CMD_REVERSE: begin
                            if (fill_reg >= FILL_W'(2)) state_next = S_REV_RD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_READ:   state_next = S_IDLE;
            S_MAX: begin
                if (idx_reg == fill_reg && !rd_pend_reg) state_next = S_IDLE;
            end
            S_REV_RD: state_next = S_REV_WA;
            S_REV_WA: state_next = S_REV_WB;
            S_REV_WB: state_next = rev_more ? S_REV_RD : S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath, memory control and result
    always_comb begin
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        rd_pend_next = 1'b0;
        first_next   = first_reg;
        max_next     = max_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        tmp_next     = tmp_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr_a  = '0;
        mem_raddr_b  = '0;
        res_fire     = 1'b0;
        res          = '0;
        res.status   = ST_OK;
        res.count    = COUNT_W'(fill_reg);

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_command)
                        CMD_PUSH: begin
                            res_fire = 1'b1;
                            if (fill_reg == FILL_W'(STACK_DEPTH)) begin
                                res.status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = fill_reg[ADDR_W-1:0];
                                mem_wdata = s_push_value;
                                fill_next = fill_reg + 1'b1;
                                res.count = COUNT_W'(fill_reg + 1'b1);
                            end
                        end
                        CMD_POP: begin
                            if (fill_reg == '0) begin
                                res_fire   = 1'b1;
                                res.status = ST_EMPTY;
                            end else begin
                                mem_raddr_a = ADDR_W'(fill_reg - 1'b1);
                                fill_next   = fill_reg - 1'b1;
                            end
                        end
                        CMD_PEEK: begin
                            if (fill_reg == '0) begin
                                res_fire   = 1'b1;
                                res.status = ST_EMPTY;
                            end else begin
                                mem_raddr_a = ADDR_W'(fill_reg - 1'b1);
                            end
                        end
                        CMD_MAX: begin
                            if (fill_reg == '0) begin
                                res_fire   = 1'b1;
                                res.status = ST_EMPTY;
                            end else begin
                                idx_next   = '0;
                                first_next = 1'b1;
                            end
                        end
                        CMD_REVERSE: begin
                            if (fill_reg < FILL_W'(2)) begin
                                res_fire = 1'b1;
                            end else begin
                                lo_next = '0;
                                hi_next = ADDR_W'(fill_reg - 1'b1);
                            end
                        end
                        CMD_CLEAR: begin
                            res_fire  = 1'b1;
                            res.value = WORD_W'(fill_reg);
                            res.count = '0;
                            fill_next = '0;
                        end
                        default: begin
                            res_fire = 1'b1;    // unused code: no-op
                        end
                    endcase
                end
            end
            S_READ: begin
                res_fire  = 1'b1;
                res.value = mem_rdata_a;
            end
            S_MAX: begin
                if (idx_reg != fill_reg) begin
                    mem_raddr_a  = idx_reg[ADDR_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
                if (rd_pend_reg) begin
                    first_next = 1'b0;
                    if (first_reg || (mem_rdata_a > max_reg)) max_next = mem_rdata_a;
                end
                if (idx_reg == fill_reg && !rd_pend_reg) begin
                    res_fire  = 1'b1;
                    res.value = max_reg;
                end
            end
            S_REV_RD: begin
                mem_raddr_a = lo_reg;
                mem_raddr_b = hi_reg;
            end
            S_REV_WA: begin
                mem_we    = 1'b1;
                mem_waddr = lo_reg;
                mem_wdata = mem_rdata_b;
                tmp_next  = mem_rdata_a;
            end
            S_REV_WB: begin
                mem_we    = 1'b1;
                mem_waddr = hi_reg;
                mem_wdata = tmp_reg;
                lo_next   = lo_reg + 1'b1;
                hi_next   = hi_reg - 1'b1;
                if (!rev_more) res_fire = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        first_reg <= first_next;
        max_reg   <= max_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        tmp_reg   <= tmp_next;
    end

    // Output register plus one skid entry; skid holds the newer result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && !m_ready) begin
                if (res_fire) begin
                    skid_reg       <= res;
                    skid_valid_reg <= 1'b1;
                end
            end else if (skid_valid_reg) begin
                out_reg     <= skid_reg;
                m_valid_reg <= 1'b1;
                if (res_fire) begin
                    skid_reg <= res;
                end else begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (res_fire) begin
                out_reg     <= res;
                m_valid_reg <= 1'b1;
            end else begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = out_reg.value;
    assign m_status       = out_reg.status;
    assign m_entry_count  = out_reg.count;

    `BSE_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= FILL_W'(STACK_DEPTH))
    `BSE_ASSERT_NOW(a_no_result_drop, aclk, aresetn, res_fire && skid_valid_reg, !m_valid_reg || m_ready)
    `BSE_ASSERT_NOW(a_idle_write_is_push, aclk, aresetn, mem_we && state_reg == S_IDLE, accept && s_command == CMD_PUSH)
    `BSE_ASSERT_NEXT(a_push_grows, aclk, aresetn, accept && s_command == CMD_PUSH && fill_reg != FILL_W'(STACK_DEPTH), fill_reg == FILL_W'($past(fill_reg) + 1'b1))

endmodule

`default_nettype wire

[bench/stack_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the stack engine, keeps a shadow stack and checks
// every result against it in request order.
module stack_checker
    import bse_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [CMD_W-1:0]          s_command,
    input  logic signed [WORD_W-1:0]  s_push_value,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [WORD_W-1:0]  m_result_value,
    input  logic [STATUS_W-1:0]       m_status,
    input  logic [COUNT_W-1:0]        m_entry_count,
    output int                        mismatches,
    output int                        replies_owed
);

    logic signed [WORD_W-1:0] shadow_stack [DEPTH];
    int                       shadow_fill;
    res_t                     stack_replies [$];

    initial begin
        mismatches   = 0;
        replies_owed = 0;
        shadow_fill  = 0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] stack_checker: %s", $realtime, msg);
    endtask

    // Applies one command to the shadow stack and returns the reply it owes.
    function automatic res_t stack_apply(input logic [CMD_W-1:0] cmd,
                                         input logic signed [WORD_W-1:0] val);
        res_t                     r;
        int                       i;
        logic signed [WORD_W-1:0] t;
        r.value  = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                if (shadow_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_stack[shadow_fill] = val;
                    shadow_fill++;
                end
            end
            CMD_POP: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    shadow_fill--;
                    r.value = shadow_stack[shadow_fill];
                end
            end
            CMD_PEEK: begin
                if (shadow_fill == 0) r.status = ST_EMPTY;
                else r.value = shadow_stack[shadow_fill-1];
            end
            CMD_MAX: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value = shadow_stack[shadow_fill-1];
                    for (i = 0; i < shadow_fill - 1; i++) begin
                        if (shadow_stack[i] > r.value) r.value = shadow_stack[i];
                    end
                end
            end
            CMD_REVERSE: begin
                for (i = 0; i < shadow_fill / 2; i++) begin
                    t = shadow_stack[i];
                    shadow_stack[i] = shadow_stack[shadow_fill-1-i];
                    shadow_stack[shadow_fill-1-i] = t;
                end
            end
            CMD_CLEAR: begin
                r.value     = shadow_fill;
                shadow_fill = 0;
            end
            default: begin
            end
        endcase
        r.count = COUNT_W'(shadow_fill);
        return r;
    endfunction

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            shadow_fill = 0;
            stack_replies.delete();
        end else begin
            // Retire first so a reply in the same cycle as its request is caught.
            if (m_valid && m_ready) begin
                if (stack_replies.size() == 0) begin
                    report_mismatch($sformatf("result with none owed: value %0d status %0d count %0d",
                                              m_result_value, m_status, m_entry_count));
                end else begin
                    want = stack_replies.pop_front();
                    if (m_result_value !== want.value)
                        report_mismatch($sformatf("value %0d, expected %0d",
                                                  m_result_value, want.value));
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_status, want.status));
                    if (m_entry_count !== want.count)
                        report_mismatch($sformatf("count %0d, expected %0d",
                                                  m_entry_count, want.count));
                end
            end
            if (s_valid && s_ready) begin
                stack_replies.push_back(stack_apply(s_command, s_push_value));
            end
        end
        replies_owed = stack_replies.size();
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

// Top of the stack engine bench: clock, reset, request stimulus and the
// result-side ready pattern. All checking lives in stack_checker.
module tb;
    import bse_pkg::*;

    // Codes with no operation behind them; the block must answer them too.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam int RANDOM_REQUESTS = 1450;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int TAIL_CYCLES     = 60;    // longer than a full-depth reverse
    localparam int LONG_HOLD       = 80;    // receiver back-pressure stretch

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic [CMD_W-1:0]          s_command     = '0;
    logic signed [WORD_W-1:0]  s_push_value  = '0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic signed [WORD_W-1:0]  m_result_value;
    logic [STATUS_W-1:0]       m_status;
    logic [COUNT_W-1:0]        m_entry_count;

    int  mismatches;
    int  replies_owed;
    int  cycles = 0;

    // Idle switches, flipped per phase so some stretches run back to back.
    bit  sender_idles   = 1'b1;
    bit  receiver_idles = 1'b1;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bounded_stack_engine_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_push_value   (s_push_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status),
        .m_entry_count  (m_entry_count)
    );

    stack_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_push_value   (s_push_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status),
        .m_entry_count  (m_entry_count),
        .mismatches     (mismatches),
        .replies_owed   (replies_owed)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one request. Called at a falling edge, returns at a falling edge.
    // A zero gap keeps s_valid high straight into the next request.
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic signed [WORD_W-1:0] val);
        int gap;
        gap = sender_idles ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_push_value <= val;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    // Stop offering and wait for every owed result to come back.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (replies_owed != 0) @(negedge aclk);
    endtask

    // kind 0 leans on push (reaches full), 1 on pop (reaches empty), 2 mixes.
    function automatic logic [CMD_W-1:0] pick_command(input int kind);
        int push_pct;
        int pop_pct;
        int r;
        push_pct = (kind == 0) ? 65 : (kind == 1) ? 20 : 40;
        pop_pct  = (kind == 0) ? 10 : (kind == 1) ? 45 : 25;
        r = $urandom_range(0, 99);
        if (r < push_pct) return CMD_PUSH;
        if (r < push_pct + pop_pct) return CMD_POP;
        r = $urandom_range(0, 99);
        if (r < 30) return CMD_PEEK;
        if (r < 60) return CMD_MAX;
        if (r < 85) return CMD_REVERSE;
        if (r < 93) return CMD_CLEAR;
        return r[0] ? CMD_SPARE_A : CMD_SPARE_B;
    endfunction

    // Mostly full-range words, with the extremes and a narrow band so that
    // the max search sees ties and sign crossings.
    function automatic logic signed [WORD_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return $signed($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Result side: random ready gaps, plus two long holds so the output
    // register and skid entry fill and s_ready has to drop.
    initial begin : result_drain
        int stall;
        int drained;
        drained = 0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (drained == 300 || drained == 1000) stall = LONG_HOLD;
            else if (receiver_idles) stall = $urandom_range(0, 10);
            else stall = 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            drained++;
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int               random_requests;
        int               kind;
        int               phase_len;
        int               phase_count;
        int               n;
        logic [CMD_W-1:0] cmd;

        random_requests = 0;
        phase_count     = 0;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: every read-type command on an empty stack, clear and
        // reverse with nothing held, and the spare codes (value ignored).
        send_request(CMD_POP, $urandom);
        send_request(CMD_PEEK, $urandom);
        send_request(CMD_MAX, $urandom);
        send_request(CMD_REVERSE, $urandom);
        send_request(CMD_CLEAR, $urandom);
        send_request(CMD_SPARE_A, $urandom);
        send_request(CMD_SPARE_B, $urandom);

        // Largest word at the bottom, then a reverse of a single entry.
        send_request(CMD_PUSH, 32'sh7FFF_FFFF);
        send_request(CMD_REVERSE, $urandom);

        // Fill to the top with the other extremes among the values.
        for (n = 0; n < STACK_DEPTH_DEF - 1; n++) begin
            if (n == 0) send_request(CMD_PUSH, 32'sh8000_0000);
            else if (n == 1) send_request(CMD_PUSH, -32'sd1);
            else if (n == 2) send_request(CMD_PUSH, 32'sd0);
            else send_request(CMD_PUSH, $urandom);
        end

        // Push refused when full, max found at the bottom, full reverse,
        // then a pop of the full stack and a clear of what is left.
        send_request(CMD_PUSH, $urandom);
        send_request(CMD_MAX, $urandom);
        send_request(CMD_REVERSE, $urandom);
        send_request(CMD_POP, $urandom);
        send_request(CMD_CLEAR, $urandom);

        // Random phases; spare codes do not count toward the total.
        while (random_requests < RANDOM_REQUESTS) begin
            kind           = $urandom_range(0, 2);
            phase_len      = $urandom_range(30, 90);
            sender_idles   = ($urandom_range(0, 2) != 0);
            receiver_idles = ($urandom_range(0, 2) != 0);
            for (n = 0; n < phase_len; n++) begin
                cmd = pick_command(kind);
                send_request(cmd, pick_value());
                if (cmd <= CMD_CLEAR) random_requests++;
            end
            phase_count++;
            // Quiet the request side now and then until all replies are in.
            if (phase_count == 1 || $urandom_range(0, 3) == 0) wait_for_drain();
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
